/* rtl/fpcs_pkg.sv */
`default_nettype none

package fpcs_pkg;

  localparam int unsigned MAX_POINTS_DEF = 64;
  localparam int unsigned CH_W           = 8;
  localparam int unsigned NUM_CH         = 3;
  localparam int unsigned IDX_W          = 6;
  localparam int unsigned CNT_W          = 7;
  localparam int unsigned SQ_W           = 2 * CH_W;
  localparam int unsigned DIST_W         = 18;
  localparam int unsigned MIN_PICKS      = 2;
  localparam int unsigned MAX_PICKS      = 64;

  typedef logic [NUM_CH-1:0][CH_W-1:0] point_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_CHECK,
    ST_FEW,
    ST_ROW,
    ST_PAIR,
    ST_PAIR_DRAIN,
    ST_EMIT_J,
    ST_EMIT_I,
    ST_SWEEP_W,
    ST_DRAIN_W,
    ST_ANCH_J,
    ST_SWEEP_M,
    ST_DRAIN_M,
    ST_EMIT_B,
    ST_DONE
  } state_e;

  // what the compare stage does with a streamed point
  typedef enum logic [1:0] {
    CMP_NONE,
    CMP_PAIR,
    CMP_WRITE,
    CMP_MIN
  } cmp_e;

  // where the store read address comes from
  typedef enum logic [2:0] {
    SRC_NONE,
    SRC_ROW,
    SRC_COL,
    SRC_BI,
    SRC_BJ,
    SRC_BEST
  } src_e;

  typedef struct packed {
    logic load_en;
    logic clr_run;
    logic row_init;
    logic row_next;
    logic col_from_row;
    logic col_clr;
    src_e rd_src;
    cmp_e cmp;
    logic anchor;
    logic emit;
    logic set_chosen;
    logic few;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_final;
    logic too_few;
    logic row_last;
    logic col_last;
    logic pipe_empty;
    logic out_free;
    logic last_pick;
  } sts_t;

endpackage

`default_nettype wire

/* rtl/fpcs_if.sv */
`default_nettype none

interface fpcs_pt_if import fpcs_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] blue;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] red;
  logic            final_point;

  modport source (output valid, blue, green, red, final_point, input ready);
  modport sink (input valid, blue, green, red, final_point, output ready);
endinterface

interface fpcs_pick_if import fpcs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] pick_index;
  logic [CH_W-1:0]  pick_blue;
  logic [CH_W-1:0]  pick_green;
  logic [CH_W-1:0]  pick_red;
  logic             too_few;
  logic             run_end;

  modport source (output valid, pick_index, pick_blue, pick_green, pick_red, too_few,
                  run_end, input ready);
  modport sink (input valid, pick_index, pick_blue, pick_green, pick_red, too_few,
                run_end, output ready);
endinterface

interface fpcs_cfg_if import fpcs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] select_count;

  modport source (output valid, select_count, input ready);
  modport sink (input valid, select_count, output ready);
endinterface

`default_nettype wire

/* rtl/farthest_point_color_sampler.sv */
// loading: one point item per cycle while idle, not during a selection; no result for a
// point without the final flag; after the final item, n points, c picks: a sweep over all
// point pairs, then nearest-distance sweeps when c exceeds 2, plus drain and emit states;
// one store read a cycle, and each result waits while the receiver stalls
// too few points: the single result follows ST_CHECK and ST_FEW; reset clears control,
// counts, chosen flags and select_count (to 2), not the point or distance stores
`default_nettype none

module farthest_point_color_sampler import fpcs_pkg::*; #(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF
) (
  input logic         clk_i,
  input logic         rst_ni,
  fpcs_pt_if.sink     pt_i,
  fpcs_pick_if.source pick_o,
  fpcs_cfg_if.sink    cfg_i
);

  cmd_t cmd;
  sts_t sts;

  fpcs_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  fpcs_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .pt_i   (pt_i),
    .pick_o (pick_o),
    .cfg_i  (cfg_i)
  );

`ifndef SYNTHESIS
  a_few_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pick_o.valid && pick_o.too_few |-> pick_o.run_end)
    else $error("too_few result without run_end");

  a_load_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pt_i.valid && pt_i.ready |-> sts.pipe_empty)
    else $error("item accepted while selection in flight");

  a_emit_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit || cmd.few |-> sts.out_free)
    else $error("result issued while output register busy");
`endif

endmodule

`default_nettype wire

/* rtl/fpcs_ctrl.sv */
`default_nettype none

module fpcs_ctrl import fpcs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: begin
        if (sts_i.in_valid && sts_i.in_final) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        state_d = sts_i.too_few ? ST_FEW : ST_ROW;
      end
      ST_FEW: begin
        if (sts_i.out_free) state_d = ST_DONE;
      end
      ST_ROW: begin
        state_d = ST_PAIR;
      end
      ST_PAIR: begin
        if (sts_i.col_last) state_d = sts_i.row_last ? ST_PAIR_DRAIN : ST_ROW;
      end
      ST_PAIR_DRAIN: begin
        if (sts_i.pipe_empty) state_d = ST_EMIT_J;
      end
      ST_EMIT_J: begin
        if (sts_i.out_free) state_d = ST_EMIT_I;
      end
      ST_EMIT_I: begin
        if (sts_i.out_free) state_d = sts_i.last_pick ? ST_DONE : ST_SWEEP_W;
      end
      ST_SWEEP_W: begin
        if (sts_i.col_last) state_d = ST_DRAIN_W;
      end
      ST_DRAIN_W: begin
        if (sts_i.pipe_empty) state_d = ST_ANCH_J;
      end
      ST_ANCH_J: begin
        state_d = ST_SWEEP_M;
      end
      ST_SWEEP_M: begin
        if (sts_i.col_last) state_d = ST_DRAIN_M;
      end
      ST_DRAIN_M: begin
        if (sts_i.pipe_empty) state_d = ST_EMIT_B;
      end
      ST_EMIT_B: begin
        if (sts_i.out_free) state_d = sts_i.last_pick ? ST_DONE : ST_SWEEP_M;
      end
      ST_DONE: begin
        state_d = ST_LOAD;
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_LOAD: begin
        cmd_o.load_en = 1'b1;
      end
      ST_CHECK: begin
        cmd_o.row_init = !sts_i.too_few;
      end
      ST_FEW: begin
        cmd_o.few = sts_i.out_free;
      end
      ST_ROW: begin
        cmd_o.rd_src       = SRC_ROW;
        cmd_o.anchor       = 1'b1;
        cmd_o.col_from_row = 1'b1;
      end
      ST_PAIR: begin
        cmd_o.rd_src   = SRC_COL;
        cmd_o.cmp      = CMP_PAIR;
        cmd_o.row_next = sts_i.col_last && !sts_i.row_last;
      end
      ST_EMIT_J: begin
        if (sts_i.out_free) begin
          cmd_o.rd_src     = SRC_BJ;
          cmd_o.emit       = 1'b1;
          cmd_o.set_chosen = 1'b1;
        end
      end
      ST_EMIT_I: begin
        if (sts_i.out_free) begin
          cmd_o.rd_src     = SRC_BI;
          cmd_o.emit       = 1'b1;
          cmd_o.anchor     = 1'b1;
          cmd_o.set_chosen = 1'b1;
          cmd_o.col_clr    = 1'b1;
        end
      end
      ST_SWEEP_W: begin
        cmd_o.rd_src = SRC_COL;
        cmd_o.cmp    = CMP_WRITE;
      end
      ST_ANCH_J: begin
        cmd_o.rd_src  = SRC_BJ;
        cmd_o.anchor  = 1'b1;
        cmd_o.col_clr = 1'b1;
      end
      ST_SWEEP_M: begin
        cmd_o.rd_src = SRC_COL;
        cmd_o.cmp    = CMP_MIN;
      end
      ST_EMIT_B: begin
        if (sts_i.out_free) begin
          cmd_o.rd_src     = SRC_BEST;
          cmd_o.emit       = 1'b1;
          cmd_o.anchor     = 1'b1;
          cmd_o.set_chosen = 1'b1;
          cmd_o.col_clr    = 1'b1;
        end
      end
      ST_DONE: begin
        cmd_o.clr_run = 1'b1;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/fpcs_dp.sv */
`default_nettype none

module fpcs_dp import fpcs_pkg::*; #(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  fpcs_pt_if.sink     pt_i,
  fpcs_pick_if.source pick_o,
  fpcs_cfg_if.sink    cfg_i
);

  localparam int unsigned IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned WW = (CW > CNT_W) ? CW : CNT_W;

  // configuration
  logic [CNT_W-1:0] sel_cnt_q;
  logic [CNT_W-1:0] cnt_eff;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_cnt_q <= CNT_W'(MIN_PICKS);
    end else if (cfg_i.valid) begin
      sel_cnt_q <= cfg_i.select_count;
    end
  end

  always_comb begin
    if (sel_cnt_q < CNT_W'(MIN_PICKS)) begin
      cnt_eff = CNT_W'(MIN_PICKS);
    end else if (sel_cnt_q > CNT_W'(MAX_PICKS)) begin
      cnt_eff = CNT_W'(MAX_PICKS);
    end else begin
      cnt_eff = sel_cnt_q;
    end
  end

  // loading
  logic [CW-1:0] load_cnt_q;
  logic          accept;
  logic          wr_pt;
  point_t        in_pt;

  assign pt_i.ready = cmd_i.load_en;
  assign accept     = pt_i.valid && cmd_i.load_en;
  assign wr_pt      = accept && (load_cnt_q != CW'(MAX_POINTS));
  assign in_pt      = {pt_i.red, pt_i.green, pt_i.blue};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_cnt_q <= '0;
    end else if (cmd_i.clr_run) begin
      load_cnt_q <= '0;
    end else if (wr_pt) begin
      load_cnt_q <= load_cnt_q + CW'(1);
    end
  end

  // sweep counters and read address
  logic [IW-1:0] row_q, col_q, bi_q, bj_q, best_q;
  logic [IW-1:0] rd_addr;
  logic          issue;

  always_comb begin
    case (cmd_i.rd_src)
      SRC_ROW:  rd_addr = row_q;
      SRC_COL:  rd_addr = col_q;
      SRC_BI:   rd_addr = bi_q;
      SRC_BJ:   rd_addr = bj_q;
      SRC_BEST: rd_addr = best_q;
      default:  rd_addr = col_q;
    endcase
  end

  assign issue = (cmd_i.rd_src != SRC_NONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      if (cmd_i.row_init) begin
        row_q <= '0;
      end else if (cmd_i.row_next) begin
        row_q <= row_q + IW'(1);
      end
      if (cmd_i.col_from_row) begin
        col_q <= row_q + IW'(1);
      end else if (cmd_i.col_clr) begin
        col_q <= '0;
      end else if (cmd_i.rd_src == SRC_COL) begin
        col_q <= col_q + IW'(1);
      end
    end
  end

  // point store and nearest distance store
  point_t             pt_mem [MAX_POINTS];
  logic [DIST_W-1:0]  nd_mem [MAX_POINTS];
  point_t             rd_pt_q;
  logic [DIST_W-1:0]  rd_nd_q;
  logic               nd_we;
  logic [DIST_W-1:0]  nd_new;
  logic [IW-1:0]      s2_idx_q;

  always_ff @(posedge clk_i) begin
    if (wr_pt) begin
      pt_mem[load_cnt_q[IW-1:0]] <= in_pt;
    end
    rd_pt_q <= pt_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (nd_we) begin
      nd_mem[s2_idx_q] <= nd_new;
    end
    rd_nd_q <= nd_mem[rd_addr];
  end

  // stage 1: read data back, squared channel differences against the anchor
  cmp_e                         s1_cmp_q;
  logic                         s1_emit_q, s1_anchor_q, s1_last_q;
  logic [IW-1:0]                s1_idx_q;
  point_t                       anchor_q;
  logic [IW-1:0]                anchor_idx_q;
  logic [NUM_CH-1:0][CH_W-1:0]  abs_d;
  logic [NUM_CH-1:0][SQ_W-1:0]  sq_d;
  logic [CNT_W-1:0]             pick_cnt_q;

  assign sts_o.last_pick = ((pick_cnt_q + CNT_W'(1)) == cnt_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_cmp_q    <= CMP_NONE;
      s1_emit_q   <= 1'b0;
      s1_anchor_q <= 1'b0;
    end else begin
      s1_cmp_q    <= cmd_i.cmp;
      s1_emit_q   <= cmd_i.emit;
      s1_anchor_q <= cmd_i.anchor;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_idx_q  <= rd_addr;
      s1_last_q <= sts_o.last_pick;
    end
    if (s1_anchor_q) begin
      anchor_q     <= rd_pt_q;
      anchor_idx_q <= s1_idx_q;
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      abs_d[c] = (rd_pt_q[c] > anchor_q[c]) ? (rd_pt_q[c] - anchor_q[c])
                                            : (anchor_q[c] - rd_pt_q[c]);
      sq_d[c]  = SQ_W'(abs_d[c] * abs_d[c]);
    end
  end

  // stage 2: distance sum, nearest update, pair and argmax compare
  cmp_e                         s2_cmp_q;
  logic [NUM_CH-1:0][SQ_W-1:0]  s2_sq_q;
  logic [DIST_W-1:0]            s2_nd_q;
  logic [DIST_W-1:0]            sum_sq;
  logic [DIST_W-1:0]            bd_q, bestd_q;
  logic                         found_q;
  logic [MAX_POINTS-1:0]        chosen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_cmp_q <= CMP_NONE;
    end else begin
      s2_cmp_q <= s1_cmp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_idx_q <= s1_idx_q;
    s2_sq_q  <= sq_d;
    s2_nd_q  <= rd_nd_q;
  end

  assign sum_sq = DIST_W'(s2_sq_q[0]) + DIST_W'(s2_sq_q[1]) + DIST_W'(s2_sq_q[2]);
  assign nd_we  = (s2_cmp_q == CMP_WRITE) || (s2_cmp_q == CMP_MIN);
  assign nd_new = ((s2_cmp_q == CMP_WRITE) || (sum_sq < s2_nd_q)) ? sum_sq : s2_nd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (cmd_i.col_clr) begin
      found_q <= 1'b0;
    end else if (s2_cmp_q == CMP_MIN && !chosen_q[s2_idx_q]) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.row_init) begin
      bd_q <= '0;
      bi_q <= '0;
      bj_q <= '0;
    end else if (s2_cmp_q == CMP_PAIR && sum_sq > bd_q) begin
      bd_q <= sum_sq;
      bi_q <= anchor_idx_q;
      bj_q <= s2_idx_q;
    end
    // lowest index wins ties: only a strictly larger distance replaces
    if (s2_cmp_q == CMP_MIN && !chosen_q[s2_idx_q] && (!found_q || nd_new > bestd_q)) begin
      bestd_q <= nd_new;
      best_q  <= s2_idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chosen_q   <= '0;
      pick_cnt_q <= '0;
    end else if (cmd_i.clr_run) begin
      chosen_q   <= '0;
      pick_cnt_q <= '0;
    end else begin
      if (cmd_i.set_chosen) chosen_q[rd_addr] <= 1'b1;
      if (cmd_i.emit) pick_cnt_q <= pick_cnt_q + CNT_W'(1);
    end
  end

  // output register
  logic             out_valid_q;
  logic [IDX_W-1:0] out_idx_q;
  point_t           out_pt_q;
  logic             out_few_q, out_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_emit_q || cmd_i.few) begin
      out_valid_q <= 1'b1;
    end else if (pick_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.few) begin
      out_idx_q <= '0;
      out_pt_q  <= '0;
      out_few_q <= 1'b1;
      out_end_q <= 1'b1;
    end else if (s1_emit_q) begin
      out_idx_q <= IDX_W'(s1_idx_q);
      out_pt_q  <= rd_pt_q;
      out_few_q <= 1'b0;
      out_end_q <= s1_last_q;
    end
  end

  assign pick_o.valid      = out_valid_q;
  assign pick_o.pick_index = out_idx_q;
  assign pick_o.pick_blue  = out_pt_q[0];
  assign pick_o.pick_green = out_pt_q[1];
  assign pick_o.pick_red   = out_pt_q[2];
  assign pick_o.too_few    = out_few_q;
  assign pick_o.run_end    = out_end_q;

  // status
  assign sts_o.in_valid   = pt_i.valid;
  assign sts_o.in_final   = pt_i.final_point;
  assign sts_o.too_few    = (WW'(load_cnt_q) < WW'(cnt_eff));
  assign sts_o.row_last   = ((CW'(row_q) + CW'(2)) == load_cnt_q);
  assign sts_o.col_last   = ((CW'(col_q) + CW'(1)) == load_cnt_q);
  assign sts_o.pipe_empty = (s1_cmp_q == CMP_NONE) && (s2_cmp_q == CMP_NONE) && !s1_anchor_q;
  assign sts_o.out_free   = !out_valid_q && !s1_emit_q;

endmodule

`default_nettype wire

/* tb/farthest_point_color_sampler_tb.sv */
module farthest_point_color_sampler_tb import fpcs_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLK_HALF      = 4;
  localparam int unsigned RESET_CYCLES  = 12;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned TAIL_CYCLES   = 20;
  localparam int unsigned CYCLE_LIMIT   = 400000;

  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } color_t;

  typedef struct {
    logic [IDX_W-1:0] index;
    color_t           color;
    logic             too_few;
    logic             run_end;
  } pick_t;

  logic clk_i     = 1'b0;
  logic rst_ni    = 1'b0;
  logic rcv_ready = 1'b0;

  fpcs_pt_if   pt_if ();
  fpcs_pick_if pick_if ();
  fpcs_cfg_if  cfg_if ();

  assign pick_if.ready = rcv_ready;

  farthest_point_color_sampler i_dut (
    .clk_i,
    .rst_ni,
    .pt_i  (pt_if),
    .pick_o(pick_if),
    .cfg_i (cfg_if)
  );

  always begin
    #(CLK_HALF) clk_i = 1'b1;
    #(CLK_HALF) clk_i = 1'b0;
  end

  // shadow of the block: stored points and the pick count register
  color_t           point_mem [MAX_POINTS_DEF];
  int unsigned      points_held;
  logic [CNT_W-1:0] pick_count_reg;
  pick_t            expected_picks [$];

  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned points_sent;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  function automatic int unsigned color_dist2(color_t a, color_t b);
    int db;
    int dg;
    int dr;
    db = int'(a.blue) - int'(b.blue);
    dg = int'(a.green) - int'(b.green);
    dr = int'(a.red) - int'(b.red);
    return int'(db * db + dg * dg + dr * dr);
  endfunction

  function automatic pick_t make_pick(int unsigned k);
    pick_t p;
    p.index   = k[IDX_W-1:0];
    p.color   = point_mem[k];
    p.too_few = 1'b0;
    p.run_end = 1'b0;
    return p;
  endfunction

  // store one point; the last point of a set runs the farthest-point selection
  task automatic predict_point(color_t c, bit is_last);
    pick_t       run_q [$];
    pick_t       few;
    bit          chosen [MAX_POINTS_DEF];
    int unsigned near_d [MAX_POINTS_DEF];
    int unsigned n, cnt, bi, bj, bd, best, bestd, d, a, b, k, r;
    bit          found;
    if (points_held < MAX_POINTS_DEF) begin
      point_mem[points_held] = c;
      points_held++;
    end
    if (!is_last) return;
    n = points_held;
    points_held = 0;
    cnt = (pick_count_reg < MIN_PICKS) ? MIN_PICKS : pick_count_reg;
    if (cnt > MAX_PICKS) cnt = MAX_PICKS;
    if (n < cnt) begin
      few.index   = '0;
      few.color   = '0;
      few.too_few = 1'b1;
      few.run_end = 1'b1;
      expected_picks = {expected_picks, few};
      return;
    end
    bi = 0;
    bj = 0;
    bd = 0;
    for (a = 0; a < n; a++) begin
      for (b = a + 1; b < n; b++) begin
        d = color_dist2(point_mem[a], point_mem[b]);
        if (d > bd) begin
          bd = d;
          bi = a;
          bj = b;
        end
      end
    end
    run_q = {run_q, make_pick(bj)};
    run_q = {run_q, make_pick(bi)};
    chosen[bi] = 1'b1;
    chosen[bj] = 1'b1;
    for (k = 0; k < n; k++) begin
      a = color_dist2(point_mem[k], point_mem[bi]);
      b = color_dist2(point_mem[k], point_mem[bj]);
      near_d[k] = (a < b) ? a : b;
    end
    for (r = 2; r < cnt; r++) begin
      found = 1'b0;
      best  = 0;
      bestd = 0;
      for (k = 0; k < n; k++) begin
        if (!chosen[k] && (!found || near_d[k] > bestd)) begin
          found = 1'b1;
          best  = k;
          bestd = near_d[k];
        end
      end
      if (!found) break;
      run_q = {run_q, make_pick(best)};
      chosen[best] = 1'b1;
      for (k = 0; k < n; k++) begin
        d = color_dist2(point_mem[k], point_mem[best]);
        if (d < near_d[k]) near_d[k] = d;
      end
    end
    run_q[run_q.size()-1].run_end = 1'b1;
    expected_picks = {expected_picks, run_q};
  endtask

  function automatic logic [CH_W-1:0] rand_channel(bit narrow);
    if (!narrow) return CH_W'($urandom_range(255));
    // few distinct levels so that distances tie often
    case ($urandom_range(3))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      default: return 8'h7F;
    endcase
  endfunction

  function automatic color_t rand_color(bit narrow);
    color_t c;
    c.blue  = rand_channel(narrow);
    c.green = rand_channel(narrow);
    c.red   = rand_channel(narrow);
    return c;
  endfunction

  function automatic logic [CNT_W-1:0] rand_count();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 70) return CNT_W'($urandom_range(2, 6));
    if (roll < 80) return CNT_W'($urandom_range(0, 1));
    if (roll < 90) return CNT_W'($urandom_range(7, 20));
    return CNT_W'($urandom_range(0, 127));
  endfunction

  task automatic send_point(color_t c, bit is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      pt_if.valid       <= 1'b0;
      pt_if.blue        <= CH_W'($urandom_range(255));
      pt_if.green       <= CH_W'($urandom_range(255));
      pt_if.red         <= CH_W'($urandom_range(255));
      pt_if.final_point <= 1'($urandom_range(1));
      @(posedge clk_i);
    end
    pt_if.valid       <= 1'b1;
    pt_if.blue        <= c.blue;
    pt_if.green       <= c.green;
    pt_if.red         <= c.red;
    pt_if.final_point <= is_last;
    @(posedge clk_i);
    while (!pt_if.ready) @(posedge clk_i);
    predict_point(c, is_last);
    points_sent++;
  endtask

  task automatic send_set(int unsigned size, bit narrow);
    for (int unsigned i = 0; i < size; i++) send_point(rand_color(narrow), i == size - 1);
  endtask

  task automatic stop_points();
    pt_if.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    stop_points();
    while (expected_picks.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_select_count(logic [CNT_W-1:0] value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_if.valid        <= 1'b1;
    cfg_if.select_count <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    pick_count_reg = value;
  endtask

  task automatic set_idling(int unsigned send_pct, int unsigned stall_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
  endtask

  // black and white pair, then a lone point that is too few for two picks
  task automatic test_two_point_extremes();
    send_point('{8'h00, 8'h00, 8'h00}, 1'b0);
    send_point('{8'hFF, 8'hFF, 8'hFF}, 1'b1);
    send_point('{8'hAA, 8'h55, 8'h0F}, 1'b1);
  endtask

  task automatic test_equal_points();
    write_select_count(CNT_W'(4));
    repeat (3) send_point('{8'h80, 8'h80, 8'h80}, 1'b0);
    send_point('{8'h80, 8'h80, 8'h80}, 1'b1);
  endtask

  task automatic test_ties();
    write_select_count(CNT_W'(3));
    send_point('{8'h00, 8'h00, 8'h00}, 1'b0);
    send_point('{8'h0A, 8'h00, 8'h00}, 1'b0);
    send_point('{8'h00, 8'h0A, 8'h00}, 1'b0);
    send_point('{8'h00, 8'h00, 8'h0A}, 1'b1);
  endtask

  task automatic test_count_limits();
    write_select_count(CNT_W'(0));
    send_set(2, 1'b0);
    write_select_count(CNT_W'(1));
    send_set(2, 1'b0);
    write_select_count(CNT_W'(127));
    send_set(3, 1'b0);
    write_select_count(CNT_W'(MAX_PICKS));
    send_set(5, 1'b0);
  endtask

  // points past the store size are dropped; the full store gives the most picks
  task automatic test_store_overflow();
    write_select_count(CNT_W'(127));
    send_set(MAX_POINTS_DEF + 3, 1'b0);
    write_select_count(CNT_W'(MAX_PICKS));
    send_set(MAX_POINTS_DEF, 1'b1);
  endtask

  task automatic test_random_sets(int unsigned n_items);
    int unsigned target;
    int unsigned roll;
    int unsigned size;
    target = points_sent + n_items;
    wait_drained();
    while (points_sent < target) begin
      roll = $urandom_range(99);
      if (roll < 15) write_select_count(rand_count());
      else if (roll < 25) wait_drained();
      size = ($urandom_range(99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, 20);
      send_set(size, $urandom_range(99) < 30);
    end
    stop_points();
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    pick_t want;
    if (rst_ni && pick_if.valid && rcv_ready) begin
      if (expected_picks.size() == 0) begin
        $error("pick item with none expected: index %0d", pick_if.pick_index);
        error_count++;
      end else begin
        want = expected_picks.pop_front();
        check_field("pick_index", want.index, pick_if.pick_index);
        check_field("pick_blue", want.color.blue, pick_if.pick_blue);
        check_field("pick_green", want.color.green, pick_if.pick_green);
        check_field("pick_red", want.color.red, pick_if.pick_red);
        check_field("too_few", want.too_few, pick_if.too_few);
        check_field("run_end", want.run_end, pick_if.run_end);
      end
    end
    rcv_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    pt_if.valid         <= 1'b0;
    pt_if.blue          <= '0;
    pt_if.green         <= '0;
    pt_if.red           <= '0;
    pt_if.final_point   <= 1'b0;
    cfg_if.valid        <= 1'b0;
    cfg_if.select_count <= '0;
    points_held    = 0;
    pick_count_reg = CNT_W'(MIN_PICKS);
    error_count    = 0;
    cycle_count    = 0;
    points_sent    = 0;
    set_idling(0, 0);
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_two_point_extremes();
    test_equal_points();
    test_ties();
    test_count_limits();

    set_idling(0, 57);
    test_store_overflow();

    set_idling(0, 0);
    test_random_sets(32);
    set_idling(57, 0);
    test_random_sets(32);
    set_idling(0, 57);
    test_random_sets(32);
    set_idling(6, 6);
    test_random_sets(32);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/fpcs_pkg.sv
rtl/fpcs_if.sv
rtl/fpcs_ctrl.sv
rtl/fpcs_dp.sv
rtl/farthest_point_color_sampler.sv
tb/farthest_point_color_sampler_tb.sv
